>>> hw/rtl/sexlex_pkg.sv
// shared types, codes and helpers for the s-expression token lexer
package sexlex_pkg;

    // result queue geometry
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    // characters the lexer reacts to
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChReturn    = 8'h0D;
    localparam logic [7:0] ChOpen      = 8'h28;
    localparam logic [7:0] ChClose     = 8'h29;
    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChLowerT    = 8'h74;
    localparam logic [7:0] ChLowerN    = 8'h6E;
    localparam logic [7:0] ChLowerR    = 8'h72;
    localparam logic [7:0] ChDigit0    = 8'h30;
    localparam logic [7:0] ChDigit9    = 8'h39;

    // lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_BARE   = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_ESC    = 3'd3,
        MODE_OCT2   = 3'd4,
        MODE_OCT3   = 3'd5
    } mode_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_BYTE  = 3'd2,
        KIND_END   = 3'd3,
        KIND_CLEAN = 3'd4,
        KIND_ERROR = 3'd5
    } kind_t;

    // one result word
    typedef struct packed {
        kind_t      kind;
        logic [7:0] token_byte;
        logic       last;
    } result_t;

    // everything one input byte produces
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } decode_t;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == ChSpace) || (b == ChTab) || (b == ChNewline) || (b == ChReturn);
    endfunction

endpackage

>>> hw/rtl/sexlex_core.sv
// lexer state machine: mode and octal accumulator, per-byte result decode
module sexlex_core
    import sexlex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output decode_t    dec
);

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [7:0] octal_sum_reg;
    logic [7:0] octal_sum_next;
    logic [7:0] digit;
    logic       is_digit;

    assign digit    = data_byte - ChDigit0;
    assign is_digit = (data_byte >= ChDigit0) && (data_byte <= ChDigit9);

    // next mode and octal accumulator
    always_comb
    begin
        mode_next      = mode_reg;
        octal_sum_next = octal_sum_reg;
        if (end_of_stream)
        begin
            mode_next      = MODE_IDLE;
            octal_sum_next = 8'd0;
        end
        else
        begin
            case (mode_reg)
                MODE_BARE:
                begin
                    if (is_space(data_byte) || (data_byte == ChClose))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_QUOTED:
                begin
                    if (data_byte == ChQuote)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (data_byte == ChBackslash)
                    begin
                        mode_next = MODE_ESC;
                    end
                end
                MODE_ESC:
                begin
                    if (is_digit)
                    begin
                        octal_sum_next = {digit[1:0], 6'd0};
                        mode_next      = MODE_OCT2;
                    end
                    else
                    begin
                        mode_next = MODE_QUOTED;
                    end
                end
                MODE_OCT2:
                begin
                    octal_sum_next = octal_sum_reg + {digit[4:0], 3'd0};
                    mode_next      = MODE_OCT3;
                end
                MODE_OCT3:
                begin
                    octal_sum_next = 8'd0;
                    mode_next      = MODE_QUOTED;
                end
                default:
                begin
                    if (data_byte == ChQuote)
                    begin
                        mode_next = MODE_QUOTED;
                    end
                    else if ((data_byte != ChOpen) && (data_byte != ChClose)
                             && !is_space(data_byte))
                    begin
                        mode_next = MODE_BARE;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    // result words for this byte
    always_comb
    begin
        dec = '0;
        if (end_of_stream)
        begin
            dec.count = 2'd1;
            case (mode_reg)
                MODE_BARE, MODE_QUOTED, MODE_ESC, MODE_OCT2, MODE_OCT3:
                    dec.res0.kind = KIND_ERROR;
                default:
                    dec.res0.kind = KIND_CLEAN;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_BARE:
                begin
                    if (is_space(data_byte))
                    begin
                        dec.count     = 2'd1;
                        dec.res0.kind = KIND_END;
                    end
                    else if (data_byte == ChClose)
                    begin
                        dec.count     = 2'd2;
                        dec.res0.kind = KIND_END;
                        dec.res1.kind = KIND_CLOSE;
                    end
                    else
                    begin
                        dec.count           = 2'd1;
                        dec.res0.kind       = KIND_BYTE;
                        dec.res0.token_byte = data_byte;
                    end
                end
                MODE_QUOTED:
                begin
                    if (data_byte == ChQuote)
                    begin
                        dec.count     = 2'd1;
                        dec.res0.kind = KIND_END;
                    end
                    else if (data_byte != ChBackslash)
                    begin
                        dec.count           = 2'd1;
                        dec.res0.kind       = KIND_BYTE;
                        dec.res0.token_byte = data_byte;
                    end
                end
                MODE_ESC:
                begin
                    if (!is_digit)
                    begin
                        dec.count     = 2'd1;
                        dec.res0.kind = KIND_BYTE;
                        if (data_byte == ChLowerT)
                            dec.res0.token_byte = ChTab;
                        else if (data_byte == ChLowerN)
                            dec.res0.token_byte = ChNewline;
                        else if (data_byte == ChLowerR)
                            dec.res0.token_byte = ChReturn;
                        else
                            dec.res0.token_byte = data_byte;
                    end
                end
                MODE_OCT2:
                begin
                    dec.count = 2'd0;
                end
                MODE_OCT3:
                begin
                    dec.count           = 2'd1;
                    dec.res0.kind       = KIND_BYTE;
                    dec.res0.token_byte = octal_sum_reg + digit;
                end
                default:
                begin
                    if (data_byte == ChOpen)
                    begin
                        dec.count     = 2'd1;
                        dec.res0.kind = KIND_OPEN;
                    end
                    else if (data_byte == ChClose)
                    begin
                        dec.count     = 2'd1;
                        dec.res0.kind = KIND_CLOSE;
                    end
                    else if ((data_byte != ChQuote) && !is_space(data_byte))
                    begin
                        dec.count           = 2'd1;
                        dec.res0.kind       = KIND_BYTE;
                        dec.res0.token_byte = data_byte;
                    end
                end
            endcase
        end
        // mark the final word of this byte
        dec.res0.last = (dec.count == 2'd1);
        dec.res1.last = (dec.count == 2'd2);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            octal_sum_reg <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            octal_sum_reg <= octal_sum_next;
        end
    end

endmodule

>>> hw/rtl/sexlex_fifo.sv
// result queue: takes up to two words per cycle, delivers one per cycle while out_ready is high
module sexlex_fifo
    import sexlex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    head
);

    result_t             entry_reg [FifoDepth];
    logic [FifoPtrW-1:0] wr_ptr_reg;
    logic [FifoPtrW-1:0] wr_ptr_next;
    logic [FifoPtrW-1:0] rd_ptr_reg;
    logic [FifoPtrW-1:0] rd_ptr_next;
    logic [FifoCntW-1:0] count_reg;
    logic [FifoCntW-1:0] count_next;
    logic                pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= FifoCntW'(FifoDepth - 2));
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FifoPtrW'(push_count);
        rd_ptr_next = rd_ptr_reg + FifoPtrW'(pop);
        count_next  = count_reg + FifoCntW'(push_count) - FifoCntW'(pop);
    end

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + FifoPtrW'(1)] <= push1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FifoCntW'(FifoDepth))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> room)
        else $error("push without room");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |=> out_valid)
        else $error("pushed word not visible");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != FifoCntW'(FifoDepth)) |->
            (FifoPtrW'(count_reg) == FifoPtrW'(wr_ptr_reg - rd_ptr_reg)))
        else $error("pointers disagree with fill count");

endmodule

>>> hw/rtl/sexlex_top.sv
// top level of the s-expression token lexer: input register, decode, result queue
//
// sexpr_token_lexer_top takes one text byte per cycle over a valid/ready channel and
// emits token words (open, close, token byte, token end, clean end, error) over a
// second valid/ready channel, with last set on the final word caused by each byte.
// Throughput is one byte per cycle as long as the output side takes a word every
// cycle; a bare token closed by ')' gives two words, which the output drains one
// after the other. An accepted byte passes through the input register and then the
// four-entry result queue before its first word appears. The input register
// only moves into the decoder when the queue has two free slots, so a stalled
// consumer backs up into in_ready once the queue holds three or more words.
module sexpr_token_lexer_top
    import sexlex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] token_byte,
    output logic       last
);

    logic       s_valid_reg;
    logic [7:0] s_byte_reg;
    logic       s_eos_reg;
    logic       room;
    logic       advance;
    decode_t    dec;
    result_t    head;

    assign advance  = s_valid_reg && room;
    assign in_ready = !s_valid_reg || advance;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s_byte_reg <= data_byte;
            s_eos_reg  <= end_of_stream;
        end
    end

    // lexer decode
    sexlex_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (s_byte_reg),
        .end_of_stream (s_eos_reg),
        .dec           (dec)
    );

    // result queue
    sexlex_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (advance ? dec.count : 2'd0),
        .push0      (dec.res0),
        .push1      (dec.res1),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head       (head)
    );

    assign kind       = head.kind;
    assign token_byte = head.token_byte;
    assign last       = head.last;

endmodule
